// ----- src/nprf_pkg.sv -----
package nprf_pkg;

	localparam int unsigned ModBitsDefault    = 32;
	localparam int unsigned MaxFactorsDefault = 10;
	localparam int unsigned ModulusWidth      = 32;
	localparam int unsigned RootWidth         = 32;

endpackage

// ----- src/nprf_if.sv -----
interface nprf_in_if;
	logic                                valid;
	logic                                ready;
	logic [nprf_pkg::ModulusWidth-1:0]   modulus;

	modport source (output valid, output modulus, input ready);
	modport sink (input valid, input modulus, output ready);
endinterface

interface nprf_out_if;
	logic                                valid;
	logic                                ready;
	logic                                accepted;
	logic [nprf_pkg::RootWidth-1:0]      primitive_root;

	modport source (output valid, output accepted, output primitive_root, input ready);
	modport sink (input valid, input accepted, input primitive_root, output ready);
endinterface

// ----- src/nprf_divider.sv -----
// Restoring divider: one quotient bit per cycle. Result of n / d and n % d.
module nprf_divider #(
	parameter int unsigned W = nprf_pkg::ModBitsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         done,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);
	localparam int unsigned CntW = $clog2(W + 1);

	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [W-1:0]    quo_q;
	logic [W:0]      rem_q;
	logic [W-1:0]    den_q;
	logic [W:0]      trial;

	// Shift in the next numerator bit and try the subtraction
	assign trial = {rem_q[W-1:0], quo_q[W-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[W-1:0], quo_q[W-1]};
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q[W-1:0];

endmodule

// ----- src/ntt_prime_primitive_root_finder_unit.sv -----
// Primitive root search modulo a prime. One modulus per transaction, one result
// per transaction. The block runs one item at a time: ready is high only while
// idle, and the result is held on the output until it is taken. All divisions go
// through one shared restoring divider (one quotient bit per cycle); one trial
// division step is an issue, the shifts through the numerator, then done.
// The primality test divides by 3, 5, 7 and so on while d <= p/d, so a 32-bit
// prime costs about 2^15 steps; factoring p-1 the same way adds more steps when
// p-1 keeps a large prime cofactor. The root search computes c^((p-1)/q) mod p
// per factor q: one division for the exponent, then up to two modular products
// per exponent bit, each an add/double step per multiplier bit. Values below 3,
// even values and composites finish as soon as they are rejected. Modulus bits
// at and above MOD_BITS are ignored.
module ntt_prime_primitive_root_finder_unit #(
	parameter int unsigned MOD_BITS    = nprf_pkg::ModBitsDefault,
	parameter int unsigned MAX_FACTORS = nprf_pkg::MaxFactorsDefault
) (
	input  logic       clk,
	input  logic       arst_n,
	nprf_in_if.sink    in_ch,
	nprf_out_if.source out_ch
);
	localparam int unsigned W    = MOD_BITS;
	localparam int unsigned FiW  = $clog2(MAX_FACTORS + 1);
	localparam int unsigned IdxW = $clog2(MAX_FACTORS);
	localparam int unsigned RW   = nprf_pkg::RootWidth;

	typedef enum logic [15:0] {
		ST_IDLE   = 16'b0000000000000001,
		ST_PCHK   = 16'b0000000000000010,
		ST_PDIV   = 16'b0000000000000100,
		ST_FSTART = 16'b0000000000001000,
		ST_FTWO   = 16'b0000000000010000,
		ST_FCHK   = 16'b0000000000100000,
		ST_FDIV   = 16'b0000000001000000,
		ST_FEND   = 16'b0000000010000000,
		ST_CNEXT  = 16'b0000000100000000,
		ST_FLOAD  = 16'b0000001000000000,
		ST_ESTART = 16'b0000010000000000,
		ST_EDIV   = 16'b0000100000000000,
		ST_PSTEP  = 16'b0001000000000000,
		ST_MUL    = 16'b0010000000000000,
		ST_RCHK   = 16'b0100000000000000,
		ST_OUT    = 16'b1000000000000000
	} state_t;

	state_t state_q;

	logic [W-1:0]   p_q;      // modulus
	logic [W-1:0]   x_q;      // remaining cofactor of p-1
	logic [W-1:0]   d_q;      // trial divisor
	logic [W-1:0]   q_q;      // current prime factor of p-1
	logic [W-1:0]   c_q;      // root candidate
	logic [W-1:0]   e_q;      // exponent
	logic [W-1:0]   r_q;      // power accumulator
	logic [W-1:0]   b_q;      // base
	logic [W-1:0]   ma_q;     // multiplicand being doubled
	logic [W-1:0]   mb_q;     // multiplier bits
	logic [W-1:0]   acc_q;    // product accumulator
	logic           msq_q;    // 0: r*=b, 1: b*=b
	logic           rdone_q;  // r*=b already done for this exponent bit
	logic           hit_q;    // still dividing out the current factor
	logic [W-1:0]   fac_q [MAX_FACTORS];
	logic [FiW-1:0] nf_q;
	logic [FiW-1:0] fi_q;
	logic           acc_ok_q;
	logic [RW-1:0]  root_q;

	logic           div_start;
	logic [W-1:0]   div_num;
	logic [W-1:0]   div_den;
	logic           div_done;
	logic [W-1:0]   div_quo;
	logic [W-1:0]   div_rem;

	logic           fac_we;
	logic [W-1:0]   fac_wd;

	logic [W:0]     mul_sum;
	logic [W:0]     mul_dbl;
	logic [W:0]     mul_sum_red;
	logic [W:0]     mul_dbl_red;

	nprf_divider #(.W(W)) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (div_quo),
		.rem   (div_rem)
	);

	// Pick divider operands by state
	always_comb begin
		div_start = 1'b0;
		div_num   = p_q;
		div_den   = d_q;
		unique case (state_q)
			ST_PCHK: div_start = (p_q >= W'(3)) && p_q[0];
			ST_FCHK: begin
				div_num   = x_q;
				div_start = 1'b1;
			end
			ST_ESTART: begin
				div_num   = p_q - W'(1);
				div_den   = q_q;
				div_start = 1'b1;
			end
			default: ;
		endcase
	end

	// Record a new distinct factor while the store has room
	always_comb begin
		fac_we = 1'b0;
		fac_wd = d_q;
		if (state_q == ST_FSTART) begin
			fac_we = 1'b1;
			fac_wd = W'(2);
		end else if (state_q == ST_FDIV && div_done && !hit_q && d_q <= div_quo &&
				div_rem == '0 && nf_q < FiW'(MAX_FACTORS)) begin
			fac_we = 1'b1;
		end else if (state_q == ST_FEND && x_q > W'(2) && nf_q < FiW'(MAX_FACTORS)) begin
			fac_we = 1'b1;
			fac_wd = x_q;
		end
	end

	always_ff @(posedge clk) begin
		if (fac_we) begin
			fac_q[nf_q[IdxW-1:0]] <= fac_wd;
		end
	end

	// One add/double step of the modular product
	assign mul_sum     = {1'b0, acc_q} + {1'b0, ma_q};
	assign mul_dbl     = {ma_q, 1'b0};
	assign mul_sum_red = (mul_sum >= {1'b0, p_q}) ? mul_sum - {1'b0, p_q} : mul_sum;
	assign mul_dbl_red = (mul_dbl >= {1'b0, p_q}) ? mul_dbl - {1'b0, p_q} : mul_dbl;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			p_q      <= '0;
			x_q      <= '0;
			d_q      <= '0;
			q_q      <= '0;
			c_q      <= '0;
			e_q      <= '0;
			r_q      <= '0;
			b_q      <= '0;
			ma_q     <= '0;
			mb_q     <= '0;
			acc_q    <= '0;
			msq_q    <= 1'b0;
			rdone_q  <= 1'b0;
			hit_q    <= 1'b0;
			nf_q     <= '0;
			fi_q     <= '0;
			acc_ok_q <= 1'b0;
			root_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_ch.valid) begin
					p_q     <= W'(in_ch.modulus);
					d_q     <= W'(3);
					nf_q    <= '0;
					state_q <= ST_PCHK;
				end
				// Reject below three and even values, else run one trial division
				ST_PCHK: begin
					if (p_q < W'(3) || !p_q[0]) begin
						acc_ok_q <= 1'b0;
						root_q   <= '0;
						state_q  <= ST_OUT;
					end else begin
						state_q <= ST_PDIV;
					end
				end
				ST_PDIV: if (div_done) begin
					if (d_q > div_quo) begin
						state_q <= ST_FSTART;
					end else if (div_rem == '0) begin
						acc_ok_q <= 1'b0;
						root_q   <= '0;
						state_q  <= ST_OUT;
					end else begin
						d_q     <= d_q + W'(2);
						state_q <= ST_PCHK;
					end
				end
				// p-1 is even: record two, then strip it
				ST_FSTART: begin
					x_q     <= p_q - W'(1);
					d_q     <= W'(3);
					hit_q   <= 1'b0;
					nf_q    <= FiW'(1);
					state_q <= ST_FTWO;
				end
				ST_FTWO: begin
					if (!x_q[0]) begin
						x_q <= x_q >> 1;
					end else begin
						state_q <= ST_FCHK;
					end
				end
				ST_FCHK: state_q <= ST_FDIV;
				// Trial division of the cofactor; divide a hit out completely
				ST_FDIV: if (div_done) begin
					state_q <= ST_FCHK;
					if (hit_q) begin
						if (div_rem == '0) begin
							x_q <= div_quo;
						end else begin
							hit_q <= 1'b0;
							d_q   <= d_q + W'(2);
						end
					end else if (d_q > div_quo) begin
						state_q <= ST_FEND;
					end else if (div_rem == '0) begin
						if (fac_we) begin
							nf_q <= nf_q + FiW'(1);
						end
						hit_q <= 1'b1;
						x_q   <= div_quo;
					end else begin
						d_q <= d_q + W'(2);
					end
				end
				ST_FEND: begin
					if (fac_we) begin
						nf_q <= nf_q + FiW'(1);
					end
					c_q     <= W'(2);
					state_q <= ST_CNEXT;
				end
				// Next root candidate
				ST_CNEXT: begin
					if (c_q >= p_q) begin
						acc_ok_q <= 1'b1;
						root_q   <= '0;
						state_q  <= ST_OUT;
					end else begin
						fi_q    <= '0;
						state_q <= ST_FLOAD;
					end
				end
				ST_FLOAD: begin
					if (fi_q == nf_q) begin
						acc_ok_q <= 1'b1;
						root_q   <= RW'(c_q);
						state_q  <= ST_OUT;
					end else begin
						q_q     <= fac_q[fi_q[IdxW-1:0]];
						state_q <= ST_ESTART;
					end
				end
				ST_ESTART: state_q <= ST_EDIV;
				ST_EDIV: if (div_done) begin
					e_q     <= div_quo;
					r_q     <= W'(1);
					b_q     <= c_q;
					rdone_q <= 1'b0;
					state_q <= ST_PSTEP;
				end
				// Square and multiply, low exponent bit first
				ST_PSTEP: begin
					if (e_q == '0) begin
						state_q <= ST_RCHK;
					end else begin
						ma_q  <= b_q;
						acc_q <= '0;
						if (e_q[0] && !rdone_q) begin
							mb_q  <= r_q;
							msq_q <= 1'b0;
						end else begin
							mb_q  <= b_q;
							msq_q <= 1'b1;
						end
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mb_q == '0) begin
						if (!msq_q) begin
							r_q     <= acc_q;
							rdone_q <= 1'b1;
						end else begin
							b_q     <= acc_q;
							e_q     <= e_q >> 1;
							rdone_q <= 1'b0;
						end
						state_q <= ST_PSTEP;
					end else begin
						if (mb_q[0]) begin
							acc_q <= mul_sum_red[W-1:0];
						end
						ma_q <= mul_dbl_red[W-1:0];
						mb_q <= mb_q >> 1;
					end
				end
				// A power of one drops the candidate
				ST_RCHK: begin
					if (r_q == W'(1)) begin
						c_q     <= c_q + W'(1);
						state_q <= ST_CNEXT;
					end else begin
						fi_q    <= fi_q + FiW'(1);
						state_q <= ST_FLOAD;
					end
				end
				ST_OUT: if (out_ch.ready) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ch.ready           = (state_q == ST_IDLE);
	assign out_ch.valid          = (state_q == ST_OUT);
	assign out_ch.accepted       = acc_ok_q;
	assign out_ch.primitive_root = root_q;

`ifndef SYNTHESIS
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q));

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.accepted) &&
			$stable(out_ch.primitive_root));

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid));

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.accepted |-> out_ch.primitive_root == '0);

	a_factor_count: assert property (@(posedge clk) disable iff (!arst_n)
		nf_q <= FiW'(MAX_FACTORS));
`endif

endmodule

// ----- dv/tb_ntt_prime_primitive_root_finder_unit.sv -----
`timescale 1ns / 1ps

module tb_ntt_prime_primitive_root_finder_unit;

	localparam int unsigned CycleLimit = 30_000_000;
	localparam int unsigned HoldOffCycles = 3000;
	localparam int unsigned DrainCycles = 200;

	// Expected outcome for one modulus
	typedef struct {
		logic [31:0]                      modulus;
		logic                             accepted;
		logic [nprf_pkg::RootWidth-1:0]   primitive_root;
	} root_result_t;

	class root_scoreboard;
		root_result_t pending_roots[$];
		int unsigned  mismatch_count;
		int unsigned  result_count;
		int unsigned  prime_count;

		function new();
			mismatch_count = 0;
			result_count   = 0;
			prime_count    = 0;
		endfunction

		function bit odd_prime(longint unsigned p);
			longint unsigned d;
			if (p < 3 || p[0] == 1'b0)
				return 1'b0;
			for (d = 3; d <= p / d; d += 2)
				if (p % d == 0)
					return 1'b0;
			return 1'b1;
		endfunction

		function longint unsigned power_mod(longint unsigned b, longint unsigned e,
				longint unsigned m);
			longint unsigned r;
			r = 1 % m;
			b = b % m;
			while (e != 0) begin
				if (e[0])
					r = (r * b) % m;
				b = (b * b) % m;
				e = e >> 1;
			end
			return r;
		endfunction

		// Work out acceptance and the smallest primitive root
		function root_result_t predict_root(logic [31:0] modulus);
			root_result_t    res;
			longint unsigned p, x, d, c;
			longint unsigned factors[$];
			bit              ok;
			p = modulus;
			res.modulus = modulus;
			res.accepted = 1'b0;
			res.primitive_root = '0;
			if (!odd_prime(p))
				return res;
			res.accepted = 1'b1;
			// distinct prime factors of p-1, ascending, capped by the store size
			x = p - 1;
			if (x[0] == 1'b0) begin
				factors.push_back(2);
				while (x[0] == 1'b0)
					x = x >> 1;
			end
			for (d = 3; d <= x / d; d += 2) begin
				if (x % d == 0) begin
					if (factors.size() < nprf_pkg::MaxFactorsDefault)
						factors.push_back(d);
					while (x % d == 0)
						x = x / d;
				end
			end
			if (x > 2 && factors.size() < nprf_pkg::MaxFactorsDefault)
				factors.push_back(x);
			for (c = 2; c < p; c++) begin
				ok = 1'b1;
				foreach (factors[i])
					if (power_mod(c, (p - 1) / factors[i], p) == 1) begin
						ok = 1'b0;
						break;
					end
				if (ok) begin
					res.primitive_root = c[31:0];
					break;
				end
			end
			return res;
		endfunction

		function void note_modulus(logic [31:0] modulus);
			root_result_t res;
			res = predict_root(modulus);
			if (res.accepted)
				prime_count++;
			pending_roots.push_back(res);
		endfunction

		function void report(string what, logic [31:0] modulus, logic [31:0] exp_v,
				logic [31:0] act_v);
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("ERROR %s for modulus %0d: expected %0d, got %0d",
					what, modulus, exp_v, act_v);
		endfunction

		function void check_result(logic accepted, logic [31:0] primitive_root);
			root_result_t res;
			result_count++;
			if (pending_roots.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("ERROR result with no modulus waiting: accepted %0b root %0d",
						accepted, primitive_root);
				return;
			end
			res = pending_roots.pop_front();
			if (accepted !== res.accepted)
				report("accepted", res.modulus, res.accepted, accepted);
			if (primitive_root !== res.primitive_root)
				report("primitive_root", res.modulus, res.primitive_root, primitive_root);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	nprf_in_if  in_ch ();
	nprf_out_if out_ch ();

	root_scoreboard sb;
	int unsigned    cycle_count;
	int unsigned    hold_cycles;
	bit             idle_enable;

	ntt_prime_primitive_root_finder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	// Clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Mismatches found");
			$finish;
		end
	end

	// Receiver: check results at the rising edge, drive ready at the falling edge
	initial begin
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
				sb.check_result(out_ch.accepted, out_ch.primitive_root);
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready <= 1'b0;
			end else if (idle_enable && $urandom_range(99) < 11)
				out_ch.ready <= 1'b0;
			else
				out_ch.ready <= 1'b1;
		end
	end

	// Offer one modulus, with an occasional gap first, and hold until accepted
	task automatic send_modulus(logic [31:0] modulus);
		int unsigned gap;
		if (idle_enable && $urandom_range(99) < 11) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			in_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_ch.valid   <= 1'b1;
		in_ch.modulus <= modulus;
		do
			@(posedge clk);
		while (in_ch.ready !== 1'b1);
		sb.note_modulus(modulus);
	endtask

	task automatic drain_results();
		while (sb.pending_roots.size() != 0)
			@(posedge clk);
	endtask

	// Random modulus, mostly small; large ones carry a small factor to stay fast
	function automatic logic [31:0] random_modulus();
		logic [31:0] r;
		int unsigned d;
		case ($urandom_range(19))
			0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: return $urandom_range(4095);
			12, 13, 14, 15: return $urandom_range(65535, 4096);
			16: return $urandom_range(1 << 24, 65536);
			default: begin
				r = $urandom;
				case ($urandom_range(3))
					0: d = 2;
					1: d = 3;
					2: d = 5;
					default: d = 7;
				endcase
				return r - (r % d);
			end
		endcase
	endfunction

	initial begin
		logic [31:0] directed[$];
		sb          = new();
		cycle_count = 0;
		hold_cycles = 0;
		idle_enable = 1'b1;
		in_ch.valid   = 1'b0;
		in_ch.modulus = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Edges of the range, below three, three, composites, primes
		directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd15,
			32'd17, 32'd49, 32'd97, 32'd257, 32'd7919, 32'd65537, 32'd1000003,
			32'd16777213, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000,
			32'hAAAA_AAAA, 32'h5555_5555, 32'd4294967295 - 32'd2};
		foreach (directed[i]) begin
			if (i == 4)
				hold_cycles = HoldOffCycles;
			send_modulus(directed[i]);
		end

		// Pause until the block has returned everything
		@(negedge clk);
		in_ch.valid <= 1'b0;
		drain_results();

		for (int n = 0; n < 80; n++) begin
			idle_enable = !(n >= 30 && n < 55);
			send_modulus(random_modulus());
		end
		@(negedge clk);
		in_ch.valid <= 1'b0;
		idle_enable = 1'b1;

		drain_results();
		repeat (DrainCycles) @(posedge clk);

		$display("Covered %0d moduli (%0d primes) with %0d results checked in %0d cycles",
			sb.result_count, sb.prime_count, sb.result_count, cycle_count);
		$display("Directed edge values, a long output stall and random moduli up to 32 bits");
		if (sb.mismatch_count == 0 && sb.pending_roots.size() == 0)
			$display("No mismatches found");
		else begin
			$display("%0d mismatches, %0d results missing", sb.mismatch_count,
				sb.pending_roots.size());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/nprf_pkg.sv
src/nprf_if.sv
src/nprf_divider.sv
src/ntt_prime_primitive_root_finder_unit.sv
dv/tb_ntt_prime_primitive_root_finder_unit.sv
